// File: rtl/round_robin_scheduler_semaphores_macros.svh
// Assertion macros shared by the scheduler checker.
`ifndef ROUND_ROBIN_SCHEDULER_SEMAPHORES_MACROS_SVH
`define ROUND_ROBIN_SCHEDULER_SEMAPHORES_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define RRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define RRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// File: rtl/rrs_pkg.sv
// Shared types, codes and defaults of the round-robin scheduler.
package rrs_pkg;

    localparam int MAX_PROCS_DEF   = 16;
    localparam int NUM_SEMS_DEF    = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    // command opcodes
    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_TICK   = 3'd1;
    localparam logic [2:0] OP_TERM   = 3'd2;
    localparam logic [2:0] OP_DOWN   = 3'd3;
    localparam logic [2:0] OP_UP     = 3'd4;
    localparam logic [2:0] OP_INIT   = 3'd5;

    // result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_HALT   = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_NOPROC = 2'd3;

    // slot states; an unused slot is never read, so empty needs no code here
    localparam logic [1:0] SLOT_ACTIVE  = 2'd1;
    localparam logic [1:0] SLOT_TERM    = 2'd2;
    localparam logic [1:0] SLOT_BLOCKED = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [2:0]         sem_index;
        logic signed [15:0] init_value;
    } rrs_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         current_proc;
        logic               switched;
        logic [3:0]         new_proc;
        logic signed [15:0] sem_count;
    } rrs_out_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       set_status;
        logic [1:0] status_code;
        logic       set_halt;
        logic       create;
        logic       term_write;
        logic       srch_start;
        logic       srch_step;
        logic       take_found;
        logic       sem_dec;
        logic       sem_block;
        logic       sem_inc;
        logic       sem_wake;
        logic       sem_relink;
        logic       sem_init;
        logic       show_cnt;
        logic       out_load;
    } rrs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic halted;
        logic is_create;
        logic is_sched;
        logic is_term;
        logic is_sem;
        logic is_down;
        logic is_up;
        logic is_init;
        logic table_full;
        logic no_procs;
        logic cnt_pos;
        logic head_valid;
        logic found;
        logic exhausted;
        logic out_busy;
    } rrs_sts_t;

endpackage

// File: rtl/round_robin_scheduler_semaphores.sv
// Top level of the round-robin scheduler with counting semaphores.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   s_      | in        | s_valid / s_ready  | rrs_in_t: opcode, sem_index,
//           |           |                    |   init_value
//   m_      | out       | m_valid / m_ready  | rrs_out_t: status, current_proc,
//           |           |                    |   switched, new_proc, sem_count
//
// One command is in flight at a time. Halted, create and unknown commands go from
// dispatch straight to the result; down, up and init first read the semaphore, and
// an up that wakes a waiter then relinks its queue. Tick, terminate and blocking down
// walk the slot table one slot per cycle through the slot RAM read port.
// Reset is synchronous on aresetn; no clearing pass is needed, unwritten stores
// are covered by the slot fill count and per-entry valid flops.
// A stalled result holds in the output register; the next command is taken once
// that result is loaded, even while it still waits on m_ready.
module round_robin_scheduler_semaphores
    import rrs_pkg::*;
#(
    parameter int MAX_PROCS   = MAX_PROCS_DEF,
    parameter int NUM_SEMS    = NUM_SEMS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rrs_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rrs_out_t m_data
);

    // command strobes down, decoded status up
    rrs_cmd_t cmd;
    rrs_sts_t sts;

    // sequence each transaction: dispatch, semaphore read, queue relink, slot search
    rrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // hold slot table, semaphore counts and queues, and the result register
    rrs_dpath #(
        .MAX_PROCS   (MAX_PROCS),
        .NUM_SEMS    (NUM_SEMS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

// File: rtl/rrs_ram.sv
// Generic simple dual-port RAM with registered read.
module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/rrs_dpath.sv
// Scheduler datapath: slot table, semaphore stores, search walker and result register.
module rrs_dpath
    import rrs_pkg::*;
#(
    parameter int MAX_PROCS   = MAX_PROCS_DEF,
    parameter int NUM_SEMS    = NUM_SEMS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  rrs_in_t  s_data,
    input  logic     m_ready,
    input  rrs_cmd_t cmd,
    output rrs_sts_t sts,
    output logic     m_valid,
    output rrs_out_t m_data
);

    localparam int PW = $clog2(MAX_PROCS);
    localparam int TW = $clog2(MAX_PROCS + 1);
    localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int CW = COUNT_WIDTH;
    localparam int EW = (CW > 16) ? CW : 16;

    localparam longint CMAX_L = (longint'(1) << (CW - 1)) - 1;
    localparam logic signed [EW-1:0] CMAX_E    = EW'(CMAX_L);
    localparam logic signed [EW-1:0] CMIN_E    = EW'(-CMAX_L - 1);
    localparam logic signed [CW-1:0] CMAX_C    = CW'(CMAX_L);
    localparam logic signed [CW-1:0] CMIN_C    = CW'(-CMAX_L - 1);
    localparam logic signed [EW-1:0] OUT_MAX_E = EW'(32767);
    localparam logic signed [EW-1:0] OUT_MIN_E = EW'(-32768);

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] idx,
                                                  input logic [TW-1:0] total);
        return ((TW'(idx) + TW'(1)) == total) ? '0 : idx + PW'(1);
    endfunction

    rrs_in_t            cmd_reg;
    logic [PW-1:0]      before_reg;
    logic [PW-1:0]      running_reg;
    logic [TW-1:0]      total_reg;
    logic               halted_reg;
    logic [1:0]         status_res_reg;
    logic [PW-1:0]      newp_reg;
    logic               show_reg;
    logic signed [15:0] cnt16_reg;
    logic [PW-1:0]      srch_idx_reg;
    logic [TW-1:0]      left_reg;
    logic [PW-1:0]      chk_idx_reg;
    logic               chk_valid_reg;
    logic [NUM_SEMS-1:0]  cnt_valid_reg;
    logic [NUM_SEMS-1:0]  head_valid_reg;
    logic [MAX_PROCS-1:0] link_valid_reg;
    logic               m_valid_reg;
    rrs_out_t           m_data_reg;

    logic [SW-1:0]      sem_addr;
    logic               si_ok;
    logic               head_v;
    logic [1:0]         slot_rd;
    logic [PW-1:0]      link_rd;
    logic [PW-1:0]      head_rd;
    logic [PW-1:0]      tail_rd;
    logic [CW-1:0]      cnt_rd;
    logic signed [CW-1:0] cnt_cur;
    logic signed [CW-1:0] cnt_new;
    logic signed [CW-1:0] cnt_after;
    logic signed [CW-1:0] init_clamped;
    logic signed [EW-1:0] ival_ext;
    logic signed [EW-1:0] cnt_after_ext;
    logic signed [15:0]   cnt_sat16;
    logic               found;

    logic               slot_we;
    logic [PW-1:0]      slot_wa;
    logic [1:0]         slot_wd;
    logic               cnt_we;
    logic               link_we;
    logic               head_we;
    logic [PW-1:0]      head_wd;

    assign sem_addr = SW'(cmd_reg.sem_index);
    assign si_ok    = int'(cmd_reg.sem_index) < NUM_SEMS;
    assign head_v   = head_valid_reg[sem_addr];
    assign cnt_cur  = cnt_valid_reg[sem_addr] ? cnt_rd : '0;
    assign found    = chk_valid_reg && (slot_rd == SLOT_ACTIVE);

    // status toward the controller
    always_comb begin
        sts.halted     = halted_reg;
        sts.is_create  = cmd_reg.opcode == OP_CREATE;
        sts.is_sched   = (cmd_reg.opcode == OP_TICK) || (cmd_reg.opcode == OP_TERM);
        sts.is_term    = cmd_reg.opcode == OP_TERM;
        sts.is_down    = cmd_reg.opcode == OP_DOWN;
        sts.is_up      = cmd_reg.opcode == OP_UP;
        sts.is_init    = cmd_reg.opcode == OP_INIT;
        sts.is_sem     = si_ok && (sts.is_down || sts.is_up || sts.is_init);
        sts.table_full = total_reg == TW'(MAX_PROCS);
        sts.no_procs   = total_reg == '0;
        sts.cnt_pos    = !cnt_cur[CW-1] && (cnt_cur != '0);
        sts.head_valid = head_v;
        sts.found      = found;
        sts.exhausted  = (left_reg == '0) && !found;
        sts.out_busy   = m_valid_reg && !m_ready;
    end

    // count arithmetic: decrement, saturating increment, clamped init
    always_comb begin
        ival_ext = EW'(cmd_reg.init_value);
        if (ival_ext > CMAX_E) begin
            init_clamped = CMAX_C;
        end else if (ival_ext < CMIN_E) begin
            init_clamped = CMIN_C;
        end else begin
            init_clamped = ival_ext[CW-1:0];
        end

        priority if (cmd.sem_dec) begin
            cnt_new = cnt_cur - CW'(1);
        end else if (cmd.sem_inc) begin
            cnt_new = (cnt_cur == CMAX_C) ? cnt_cur : cnt_cur + CW'(1);
        end else begin
            cnt_new = init_clamped;
        end

        cnt_we    = cmd.sem_dec || cmd.sem_inc || cmd.sem_init;
        cnt_after = cnt_we ? cnt_new : cnt_cur;

        cnt_after_ext = EW'(cnt_after);
        if (cnt_after_ext > OUT_MAX_E) begin
            cnt_sat16 = 16'sh7fff;
        end else if (cnt_after_ext < OUT_MIN_E) begin
            cnt_sat16 = 16'sh8000;
        end else begin
            cnt_sat16 = cnt_after_ext[15:0];
        end
    end

    // write port steering
    always_comb begin
        slot_we = cmd.create || cmd.term_write || cmd.sem_block || cmd.sem_wake;
        priority if (cmd.create) begin
            slot_wa = PW'(total_reg);
            slot_wd = SLOT_ACTIVE;
        end else if (cmd.sem_wake) begin
            slot_wa = head_rd;
            slot_wd = SLOT_ACTIVE;
        end else if (cmd.term_write) begin
            slot_wa = running_reg;
            slot_wd = SLOT_TERM;
        end else begin
            slot_wa = running_reg;
            slot_wd = SLOT_BLOCKED;
        end
        link_we = cmd.sem_block && head_v;
        head_we = (cmd.sem_block && !head_v) || cmd.sem_relink;
        head_wd = cmd.sem_relink ? link_rd : running_reg;
    end

    rrs_ram #(.WIDTH(2), .DEPTH(MAX_PROCS)) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (slot_we),
        .wr_addr (slot_wa),
        .wr_data (slot_wd),
        .rd_addr (srch_idx_reg),
        .rd_data (slot_rd)
    );

    rrs_ram #(.WIDTH(PW), .DEPTH(MAX_PROCS)) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_we),
        .wr_addr (tail_rd),
        .wr_data (running_reg),
        .rd_addr (head_rd),
        .rd_data (link_rd)
    );

    rrs_ram #(.WIDTH(PW), .DEPTH(NUM_SEMS)) u_head_ram (
        .aclk    (aclk),
        .wr_en   (head_we),
        .wr_addr (sem_addr),
        .wr_data (head_wd),
        .rd_addr (sem_addr),
        .rd_data (head_rd)
    );

    rrs_ram #(.WIDTH(PW), .DEPTH(NUM_SEMS)) u_tail_ram (
        .aclk    (aclk),
        .wr_en   (cmd.sem_block),
        .wr_addr (sem_addr),
        .wr_data (running_reg),
        .rd_addr (sem_addr),
        .rd_data (tail_rd)
    );

    rrs_ram #(.WIDTH(CW), .DEPTH(NUM_SEMS)) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (sem_addr),
        .wr_data (cnt_new),
        .rd_addr (sem_addr),
        .rd_data (cnt_rd)
    );

    // scheduler control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg    <= '0;
            total_reg      <= '0;
            halted_reg     <= 1'b0;
            chk_valid_reg  <= 1'b0;
            cnt_valid_reg  <= '0;
            head_valid_reg <= '0;
            link_valid_reg <= '0;
        end else begin
            if (cmd.set_halt) begin
                halted_reg <= 1'b1;
            end
            if (cmd.create) begin
                total_reg <= total_reg + TW'(1);
                link_valid_reg[PW'(total_reg)] <= 1'b0;
                if (total_reg == '0) begin
                    running_reg <= '0;
                end
            end
            if (cmd.srch_start) begin
                chk_valid_reg <= 1'b0;
            end else if (cmd.srch_step) begin
                chk_valid_reg <= left_reg != '0;
            end
            if (cmd.take_found) begin
                running_reg <= chk_idx_reg;
            end
            if (cnt_we) begin
                cnt_valid_reg[sem_addr] <= 1'b1;
            end
            if (cmd.sem_block) begin
                // clear first so a link set below wins, as the queue append expects
                link_valid_reg[running_reg] <= 1'b0;
                if (head_v) begin
                    link_valid_reg[tail_rd] <= 1'b1;
                end else begin
                    head_valid_reg[sem_addr] <= 1'b1;
                end
            end
            if (cmd.sem_wake) begin
                head_valid_reg[sem_addr] <= link_valid_reg[head_rd];
                link_valid_reg[head_rd]  <= 1'b0;
            end
            if (cmd.sem_init) begin
                head_valid_reg[sem_addr] <= 1'b0;
            end
        end
    end

    // transaction payload and search walker, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg        <= s_data;
            before_reg     <= running_reg;
            status_res_reg <= STAT_OK;
            newp_reg       <= '0;
            show_reg       <= 1'b0;
        end
        if (cmd.set_status) begin
            status_res_reg <= cmd.status_code;
        end
        if (cmd.create) begin
            newp_reg <= PW'(total_reg);
        end
        if (cmd.show_cnt) begin
            show_reg  <= 1'b1;
            cnt16_reg <= cnt_sat16;
        end
        if (cmd.srch_start) begin
            srch_idx_reg <= next_slot(running_reg, total_reg);
            left_reg     <= total_reg;
        end else if (cmd.srch_step && (left_reg != '0)) begin
            chk_idx_reg  <= srch_idx_reg;
            srch_idx_reg <= next_slot(srch_idx_reg, total_reg);
            left_reg     <= left_reg - TW'(1);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.status       <= status_res_reg;
            m_data_reg.current_proc <= 4'(running_reg);
            m_data_reg.switched     <= running_reg != before_reg;
            m_data_reg.new_proc     <= 4'(newp_reg);
            m_data_reg.sem_count    <= show_reg ? cnt16_reg : 16'sd0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/rrs_ctrl.sv
// Scheduler controller: sequences each command through dispatch, semaphore, search and result.
module rrs_ctrl
    import rrs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rrs_sts_t sts,
    output rrs_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_SEMRD    = 6'b000100,
        S_UPLINK   = 6'b001000,
        S_SEARCH   = 6'b010000,
        S_DONE     = 6'b100000
    } rrs_state_t;

    rrs_state_t state_reg;
    rrs_state_t state_next;

    assign s_ready = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (sts.halted) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STAT_HALT;
                    state_next      = S_DONE;
                end else if (sts.is_create) begin
                    if (sts.table_full) begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = STAT_FULL;
                    end else begin
                        cmd.create = 1'b1;
                    end
                    state_next = S_DONE;
                end else if (sts.is_sched) begin
                    if (sts.no_procs) begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = STAT_NOPROC;
                        state_next      = S_DONE;
                    end else begin
                        cmd.term_write = sts.is_term;
                        cmd.srch_start = 1'b1;
                        state_next     = S_SEARCH;
                    end
                end else if (sts.is_sem) begin
                    state_next = S_SEMRD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SEMRD: begin
                cmd.show_cnt = 1'b1;
                priority if (sts.is_down) begin
                    priority if (sts.cnt_pos) begin
                        cmd.sem_dec = 1'b1;
                        state_next  = S_DONE;
                    end else if (sts.no_procs) begin
                        cmd.set_halt    = 1'b1;
                        cmd.set_status  = 1'b1;
                        cmd.status_code = STAT_HALT;
                        state_next      = S_DONE;
                    end else begin
                        cmd.sem_block  = 1'b1;
                        cmd.srch_start = 1'b1;
                        state_next     = S_SEARCH;
                    end
                end else if (sts.is_up) begin
                    if (sts.head_valid) begin
                        cmd.sem_wake = 1'b1;
                        state_next   = S_UPLINK;
                    end else begin
                        cmd.sem_inc = 1'b1;
                        state_next  = S_DONE;
                    end
                end else begin
                    cmd.sem_init = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_UPLINK: begin
                cmd.sem_relink = 1'b1;
                state_next     = S_DONE;
            end
            S_SEARCH: begin
                cmd.srch_step = 1'b1;
                if (sts.found) begin
                    cmd.take_found = 1'b1;
                    state_next     = S_DONE;
                end else if (sts.exhausted) begin
                    cmd.set_halt    = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STAT_HALT;
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/rrs_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`include "round_robin_scheduler_semaphores_macros.svh"

module rrs_checker
    import rrs_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input rrs_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input rrs_out_t m_data
);

    logic halted_seen_reg;

    // remember a delivered halted result; halting is sticky
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halted_seen_reg <= 1'b0;
        end else if (m_valid && m_ready && (m_data.status == STAT_HALT)) begin
            halted_seen_reg <= 1'b1;
        end
    end

    `RRS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    `RRS_ASSERT_NOW(a_halt_sticky, halted_seen_reg && m_valid, (m_data.status == STAT_HALT) && !m_data.switched && (m_data.new_proc == 4'd0) && (m_data.sem_count == 16'sd0))
    `RRS_ASSERT_NOW(a_fail_no_switch, m_valid && (m_data.status != STAT_OK), !m_data.switched)
    `RRS_ASSERT_NOW(a_create_ok, m_valid && (m_data.new_proc != 4'd0), (m_data.status == STAT_OK) && !m_data.switched)

endmodule

bind round_robin_scheduler_semaphores rrs_checker u_checker (.*);
